@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_HOLD(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// condition must never be true outside reset
`define ASSERT_NEVER(name, clk, rstn, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`else

`define ASSERT_HOLD(name, clk, rstn, prop, msg)
`define ASSERT_NEVER(name, clk, rstn, cond, msg)

`endif

`endif

@@ rtl/gbs_pkg.sv @@
// ----------------------------------------------------------------------------
// gbs_pkg
// types and constants of the greedy box suppression block
// ----------------------------------------------------------------------------
package gbs_pkg;

    // one input word: a box as top-left corner and size plus the frame end flag
    typedef struct packed {
        logic signed [15:0] box_left;
        logic signed [15:0] box_top;
        logic        [14:0] box_width;
        logic        [14:0] box_height;
        logic               frame_end;
    } box_in_t;

    // one result word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] box_index;
        logic        frame_done;
    } box_out_t;

    // one entry of the kept-box store
    typedef struct packed {
        logic signed [15:0] kept_left;
        logic signed [15:0] kept_top;
        logic        [14:0] kept_wide;
        logic        [14:0] kept_tall;
        logic        [29:0] kept_area;
    } kept_entry_t;

    // status codes
    localparam logic [1:0] STATUS_SUPPRESSED = 2'd0;
    localparam logic [1:0] STATUS_KEPT       = 2'd1;
    localparam logic [1:0] STATUS_FULL       = 2'd2;

    // threshold after reset, 0.45 in Q0.16
    localparam logic [15:0] IOU_THRESHOLD_RESET = 16'd29491;

endpackage

@@ rtl/greedy_box_suppression.sv @@
// ----------------------------------------------------------------------------
// greedy_box_suppression
// A new box is accepted only in the idle state, once the previous box has been scanned
// against every kept box and its result moved to the output register. The scan is
// set by the single read port of the kept-box store, one kept box compared per cycle.
// A finished result waits in the output register while the next box is scanned.
// Reset (synchronous, active low) empties the store, clears the box index and
// loads the threshold with 0.45; store contents are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module greedy_box_suppression #(
    parameter int MAX_KEPT = 64
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration
    input  logic              cfg_we,
    input  logic [15:0]       cfg_wdata,
    // box input
    input  logic              s_valid,
    output logic              s_ready,
    input  gbs_pkg::box_in_t  s_data,
    // result output
    output logic              m_valid,
    input  logic              m_ready,
    output gbs_pkg::box_out_t m_data
);
    import gbs_pkg::*;

    localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CW = $clog2(MAX_KEPT + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // kept-box store
    kept_entry_t mem [MAX_KEPT];
    kept_entry_t mem_q_reg;

    logic [15:0]   thr_reg;
    logic [CW-1:0] kept_cnt_reg;
    logic [CW-1:0] issue_cnt_reg;
    logic [15:0]   box_cnt_reg;
    box_in_t       item_reg;
    logic [29:0]   item_area_reg;
    logic          hit_reg;

    logic          rd_vld_reg, a_vld_reg, b_vld_reg, c_vld_reg;
    logic [14:0]   iw_reg, ih_reg;
    logic [29:0]   ka_reg, kb_reg;
    logic [29:0]   inter_reg, inter_c_reg;
    logic [30:0]   uni_reg;

    box_out_t      m_data_reg;
    logic          m_valid_reg;

    logic          accept, rd_issue, pipe_busy, scan_end, out_free, emit;
    logic          store_full, mem_we;
    logic [1:0]    status_w;

    logic signed [16:0] ax1, bx1, ay1, by1, hx, hy;
    logic signed [15:0] lx, ly;
    logic        [17:0] dx, dy;
    logic [46:0]   prod;
    logic [45:0]   inter_sh;

    assign accept     = s_valid && s_ready;
    assign s_ready    = (state_reg == ST_IDLE);
    assign rd_issue   = (state_reg == ST_SCAN) && (issue_cnt_reg != kept_cnt_reg);
    assign pipe_busy  = rd_vld_reg || a_vld_reg || b_vld_reg || c_vld_reg;
    assign scan_end   = (state_reg == ST_SCAN) && !rd_issue && !pipe_busy;
    assign out_free   = !m_valid_reg || m_ready;
    assign emit       = (state_reg == ST_DONE) && out_free;
    assign store_full = (kept_cnt_reg == CW'(MAX_KEPT));
    assign mem_we     = emit && !hit_reg && !store_full;

    always_comb begin
        if (hit_reg) begin
            status_w = STATUS_SUPPRESSED;
        end else if (store_full) begin
            status_w = STATUS_FULL;
        end else begin
            status_w = STATUS_KEPT;
        end
    end

    // state sequencing
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept)   state_next = ST_SCAN;
            ST_SCAN: if (scan_end) state_next = ST_DONE;
            ST_DONE: if (emit)     state_next = ST_IDLE;
            default:               state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // threshold register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= IOU_THRESHOLD_RESET;
        end else if (cfg_we) begin
            thr_reg <= cfg_wdata;
        end
    end

    // captured box and its area
    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg      <= s_data;
            item_area_reg <= 30'(s_data.box_width) * 30'(s_data.box_height);
        end
    end

    // store write and registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[kept_cnt_reg[AW-1:0]] <= '{
                kept_left: item_reg.box_left,
                kept_top:  item_reg.box_top,
                kept_wide: item_reg.box_width,
                kept_tall: item_reg.box_height,
                kept_area: item_area_reg
            };
        end
        if (rd_issue) begin
            mem_q_reg <= mem[issue_cnt_reg[AW-1:0]];
        end
    end

    // read issue counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            issue_cnt_reg <= '0;
        end else if (accept) begin
            issue_cnt_reg <= '0;
        end else if (rd_issue) begin
            issue_cnt_reg <= issue_cnt_reg + CW'(1);
        end
    end

    // stage a: overlap along each axis
    always_comb begin
        ax1 = $signed({item_reg.box_left[15], item_reg.box_left})
            + $signed({2'b00, item_reg.box_width});
        bx1 = $signed({mem_q_reg.kept_left[15], mem_q_reg.kept_left})
            + $signed({2'b00, mem_q_reg.kept_wide});
        ay1 = $signed({item_reg.box_top[15], item_reg.box_top})
            + $signed({2'b00, item_reg.box_height});
        by1 = $signed({mem_q_reg.kept_top[15], mem_q_reg.kept_top})
            + $signed({2'b00, mem_q_reg.kept_tall});
        lx  = (item_reg.box_left > mem_q_reg.kept_left) ? item_reg.box_left
                                                         : mem_q_reg.kept_left;
        ly  = (item_reg.box_top > mem_q_reg.kept_top) ? item_reg.box_top
                                                       : mem_q_reg.kept_top;
        hx  = (ax1 < bx1) ? ax1 : bx1;
        hy  = (ay1 < by1) ? ay1 : by1;
        dx  = {hx[16], hx} - {{2{lx[15]}}, lx};
        dy  = {hy[16], hy} - {{2{ly[15]}}, ly};
    end

    // stage d: scaled intersection against threshold times union
    assign prod     = 47'(thr_reg) * 47'(uni_reg);
    assign inter_sh = {inter_c_reg, 16'h0000};

    // compare pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg <= 1'b0;
            a_vld_reg  <= 1'b0;
            b_vld_reg  <= 1'b0;
            c_vld_reg  <= 1'b0;
        end else begin
            rd_vld_reg <= rd_issue;
            a_vld_reg  <= rd_vld_reg;
            b_vld_reg  <= a_vld_reg;
            c_vld_reg  <= b_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        // stage a
        iw_reg      <= (!dx[17] && (dx != '0)) ? dx[14:0] : '0;
        ih_reg      <= (!dy[17] && (dy != '0)) ? dy[14:0] : '0;
        ka_reg      <= mem_q_reg.kept_area;
        // stage b
        inter_reg   <= 30'(iw_reg) * 30'(ih_reg);
        kb_reg      <= ka_reg;
        // stage c
        uni_reg     <= {1'b0, item_area_reg} + {1'b0, kb_reg} - {1'b0, inter_reg};
        inter_c_reg <= inter_reg;
    end

    // suppression flag, or of every comparison
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hit_reg <= 1'b0;
        end else if (accept) begin
            hit_reg <= 1'b0;
        end else if (c_vld_reg && ({1'b0, inter_sh} > prod)) begin
            hit_reg <= 1'b1;
        end
    end

    // kept count and box index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kept_cnt_reg <= '0;
            box_cnt_reg  <= '0;
        end else if (emit) begin
            if (item_reg.frame_end) begin
                kept_cnt_reg <= '0;
                box_cnt_reg  <= '0;
            end else begin
                if (mem_we) begin
                    kept_cnt_reg <= kept_cnt_reg + CW'(1);
                end
                if (box_cnt_reg != 16'hFFFF) begin
                    box_cnt_reg <= box_cnt_reg + 16'd1;
                end
            end
        end
    end

    // output word register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_data_reg.status     <= status_w;
            m_data_reg.box_index  <= box_cnt_reg;
            m_data_reg.frame_done <= item_reg.frame_end;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // checks
    `ASSERT_NEVER(a_kept_bound, aclk, aresetn, kept_cnt_reg > CW'(MAX_KEPT), "kept count over capacity")
    `ASSERT_NEVER(a_rd_wr_overlap, aclk, aresetn, rd_issue && mem_we, "store read and write collide")
    `ASSERT_NEVER(a_ready_busy, aclk, aresetn, s_ready && pipe_busy, "input ready during compare")
    `ASSERT_HOLD(a_emit_done, aclk, aresetn, emit |=> (m_valid_reg && (state_reg == ST_IDLE)), "result not posted")

endmodule

@@ bench/greedy_box_suppression_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_suppression_tb
// Self-checking bench for the greedy box suppression block. A short table of
// directed boxes covers edge coordinates, empty boxes and threshold extremes.
// Random frames follow: clustered boxes, grid frames that fill the kept store,
// and raw noise words. Every result word is checked against a shadow model of the kept
// store, updated as each box word is accepted; fixed table rows set the expected status.
// ----------------------------------------------------------------------------
module greedy_box_suppression_tb;
    import gbs_pkg::*;

    localparam int STORE_DEPTH      = 64;
    localparam int SETTLE_CYCLES    = STORE_DEPTH + 12;
    localparam int HOLD_CYCLES      = 300;
    localparam int WATCHDOG_LIMIT   = 4000;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int IDLE_PERCENT     = 34;

    // one line of the directed table
    typedef struct {
        logic        wr_thr;
        logic [15:0] thr;
        box_in_t     box;
        logic        fixed;
        logic [1:0]  want;
    } plan_row_t;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     cfg_we    = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    box_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    box_out_t m_data;

    // shadow copy of the block state
    kept_entry_t shadow_store [STORE_DEPTH];
    int          shadow_kept  = 0;
    logic [15:0] shadow_index = '0;
    logic [15:0] shadow_thr   = IOU_THRESHOLD_RESET;

    box_out_t  verdicts_due [$];
    box_out_t  head_verdict;
    plan_row_t plan [$];

    bit steady       = 1'b0;
    bit backlog_hold = 1'b0;
    int fail_count   = 0;
    int boxes_sent   = 0;
    int results_seen = 0;
    int seen_kept    = 0;
    int seen_supp    = 0;
    int seen_full    = 0;
    int holds_done   = 0;
    int thr_writes   = 0;

    greedy_box_suppression #(
        .MAX_KEPT(STORE_DEPTH)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    always #10 aclk = ~aclk;

    // overlap of [a0, a0+aw) and [b0, b0+bw), no wrap
    function automatic longint span_overlap(int a0, int aw, int b0, int bw);
        int a1, b1, lo, hi;
        a1 = a0 + aw;
        b1 = b0 + bw;
        lo = (a0 > b0) ? a0 : b0;
        hi = (a1 < b1) ? a1 : b1;
        return (hi > lo) ? longint'(hi - lo) : 64'sd0;
    endfunction

    // suppression verdict for one box, updates the shadow store
    function automatic box_out_t judge_box(box_in_t b);
        int left, top, wide, tall, i;
        longint unsigned area, iw, ih, inter, uni, thr_wide;
        logic keep;
        box_out_t r;
        left     = int'($signed(b.box_left));
        top      = int'($signed(b.box_top));
        wide     = int'(b.box_width);
        tall     = int'(b.box_height);
        area     = longint'(wide) * longint'(tall);
        thr_wide = longint'(shadow_thr);
        keep     = 1'b1;
        for (i = 0; i < shadow_kept; i++) begin
            iw = span_overlap(left, wide, int'($signed(shadow_store[i].kept_left)),
                              int'(shadow_store[i].kept_wide));
            ih = span_overlap(top, tall, int'($signed(shadow_store[i].kept_top)),
                              int'(shadow_store[i].kept_tall));
            inter = iw * ih;
            uni   = area + longint'(shadow_store[i].kept_area) - inter;
            if ((inter << 16) > thr_wide * uni)
                keep = 1'b0;
        end
        if (!keep) begin
            r.status = STATUS_SUPPRESSED;
        end else if (shadow_kept >= STORE_DEPTH) begin
            r.status = STATUS_FULL;
        end else begin
            shadow_store[shadow_kept].kept_left = b.box_left;
            shadow_store[shadow_kept].kept_top  = b.box_top;
            shadow_store[shadow_kept].kept_wide = b.box_width;
            shadow_store[shadow_kept].kept_tall = b.box_height;
            shadow_store[shadow_kept].kept_area = 30'(area);
            shadow_kept++;
            r.status = STATUS_KEPT;
        end
        r.box_index  = shadow_index;
        r.frame_done = b.frame_end;
        if (shadow_index != 16'hFFFF)
            shadow_index++;
        if (b.frame_end) begin
            shadow_kept  = 0;
            shadow_index = '0;
        end
        return r;
    endfunction

    function automatic box_in_t make_box(int l, int t, int w, int h, logic fe);
        box_in_t b;
        b.box_left   = 16'(l);
        b.box_top    = 16'(t);
        b.box_width  = 15'(w);
        b.box_height = 15'(h);
        b.frame_end  = fe;
        return b;
    endfunction

    function automatic plan_row_t plan_step(logic wr, int thr, int l, int t, int w, int h,
                                            logic fe, logic fixed, logic [1:0] want);
        plan_row_t p;
        p.wr_thr = wr;
        p.thr    = 16'(thr);
        p.box    = make_box(l, t, w, h, fe);
        p.fixed  = fixed;
        p.want   = want;
        return p;
    endfunction

    // append one row to the directed table
    function automatic void add_row(plan_row_t p);
        plan.insert(plan.size(), p);
    endfunction

    function automatic box_in_t noise_box();
        box_in_t b;
        b.box_left   = 16'($urandom);
        b.box_top    = 16'($urandom);
        b.box_width  = 15'($urandom);
        b.box_height = 15'($urandom);
        b.frame_end  = ($urandom_range(7) == 0);
        return b;
    endfunction

    function automatic void log_fault(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // present one box word, hold it until accepted, then queue its verdict
    task automatic offer_box(input box_in_t b, input logic fixed, input logic [1:0] want);
        box_out_t v;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        v = judge_box(b);
        if (fixed)
            v.status = want;
        verdicts_due.insert(verdicts_due.size(), v);
        boxes_sent++;
    endtask

    // threshold write once the block has drained
    task automatic write_threshold(input logic [15:0] v);
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we     <= 1'b0;
        shadow_thr  = v;
        thr_writes++;
    endtask

    // a few overlapping groups of boxes, one frame
    task automatic cluster_frame();
        int count, hubs, j, k, w, h, dx, dy;
        int hx [3];
        int hy [3];
        count = $urandom_range(1, 12);
        hubs  = $urandom_range(1, 3);
        for (j = 0; j < hubs; j++) begin
            hx[j] = int'($urandom_range(0, 40000)) - 20000;
            hy[j] = int'($urandom_range(0, 40000)) - 20000;
        end
        for (k = 0; k < count; k++) begin
            j  = $urandom_range(0, hubs - 1);
            w  = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(16, 800));
            h  = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(16, 800));
            dx = int'($urandom_range(0, 120)) - 60;
            dy = int'($urandom_range(0, 120)) - 60;
            offer_box(make_box(hx[j] + dx, hy[j] + dy, w, h, k == count - 1),
                      1'b0, STATUS_SUPPRESSED);
        end
    endtask

    // disjoint boxes on a grid until the store fills, with repeats once full
    task automatic grid_frame();
        int count, k, slot, bx, by, w, h;
        count = $urandom_range(72, 80);
        bx    = int'($urandom_range(0, 20000)) - 10000;
        by    = int'($urandom_range(0, 20000)) - 10000;
        for (k = 0; k < count; k++) begin
            slot = (k >= STORE_DEPTH && $urandom_range(3) == 0) ?
                   int'($urandom_range(0, k - 1)) : k;
            w = $urandom_range(120, 220);
            h = $urandom_range(120, 220);
            offer_box(make_box(bx + (slot % 10) * 256, by + (slot / 10) * 256, w, h,
                               k == count - 1), 1'b0, STATUS_SUPPRESSED);
        end
    endtask

    // random mix of frames and noise, closed with a frame end
    task automatic mixed_phase(input int quota);
        int goal, pick;
        goal = boxes_sent + quota;
        while (boxes_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 15)
                offer_box(noise_box(), 1'b0, STATUS_SUPPRESSED);
            else if (pick < 19)
                grid_frame();
            else
                cluster_frame();
        end
        offer_box(make_box(0, 0, 16, 16, 1'b1), 1'b0, STATUS_SUPPRESSED);
    endtask

    // result side: random ready, with one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (backlog_hold) begin
                backlog_hold = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                holds_done++;
            end else begin
                m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    // result check against the oldest pending verdict
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (verdicts_due.size() == 0) begin
                log_fault($sformatf("result with nothing pending: status %0d index %0d",
                                    m_data.status, m_data.box_index));
            end else begin
                head_verdict = verdicts_due.pop_front();
                if (m_data.status !== head_verdict.status ||
                    m_data.box_index !== head_verdict.box_index ||
                    m_data.frame_done !== head_verdict.frame_done)
                    log_fault($sformatf(
                        "word %0d: expected status %0d index %0d done %0b, got %0d %0d %0b",
                        results_seen, head_verdict.status, head_verdict.box_index,
                        head_verdict.frame_done, m_data.status, m_data.box_index,
                        m_data.frame_done));
            end
            results_seen++;
            case (m_data.status)
                STATUS_KEPT:       seen_kept++;
                STATUS_FULL:       seen_full++;
                STATUS_SUPPRESSED: seen_supp++;
                default: ;
            endcase
        end
    end

    // watchdog on cycles without any accepted word
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // stimulus sequence
    initial begin
        int r;
        // threshold at reset value
        add_row(plan_step(0, 0, 0, 0, 160, 160, 0, 1, STATUS_KEPT));
        add_row(plan_step(0, 0, 0, 0, 160, 160, 0, 1, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 1600, 1600, 160, 160, 0, 1, STATUS_KEPT));
        add_row(plan_step(0, 0, 80, 0, 160, 160, 0, 0, STATUS_SUPPRESSED));
        // empty boxes against filled and against each other
        add_row(plan_step(0, 0, 0, 0, 0, 160, 0, 1, STATUS_KEPT));
        add_row(plan_step(0, 0, 0, 0, 160, 0, 0, 1, STATUS_KEPT));
        // coordinate and size extremes, right edge past the 16 bit range
        add_row(plan_step(0, 0, -32768, -32768, 32767, 32767, 0, 0, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 32767, 32767, 32767, 32767, 0, 0, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 32766, 32766, 32767, 32767, 0, 0, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, -160, -160, 320, 320, 0, 0, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 0, 0, 160, 160, 1, 1, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 0, 0, 160, 160, 0, 1, STATUS_KEPT));
        // threshold zero: any overlap suppresses, touching does not
        add_row(plan_step(1, 0, 159, 159, 160, 160, 0, 1, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 160, 0, 160, 160, 0, 1, STATUS_KEPT));
        add_row(plan_step(0, 0, 0, 0, 0, 0, 0, 1, STATUS_KEPT));
        add_row(plan_step(0, 0, 0, 0, 0, 0, 1, 1, STATUS_KEPT));
        // threshold max: only identical boxes suppress
        add_row(plan_step(1, 65535, 0, 0, 160, 160, 0, 1, STATUS_KEPT));
        add_row(plan_step(0, 0, 0, 0, 160, 160, 0, 1, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, 0, 0, 160, 161, 0, 0, STATUS_SUPPRESSED));
        add_row(plan_step(0, 0, -32768, 32767, 0, 32767, 1, 0, STATUS_SUPPRESSED));
        // back to the reset threshold
        add_row(plan_step(1, int'(IOU_THRESHOLD_RESET), 32767, -32768, 32767, 0, 0,
                          1, STATUS_KEPT));
        add_row(plan_step(0, 0, -32768, -32768, 0, 0, 1, 0, STATUS_SUPPRESSED));

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].wr_thr)
                write_threshold(plan[r].thr);
            offer_box(plan[r].box, plan[r].fixed, plan[r].want);
        end

        // random frames over several thresholds
        write_threshold(16'($urandom));
        grid_frame();
        mixed_phase(RANDOM_PER_PHASE);

        write_threshold(16'd0);
        backlog_hold = 1'b1;
        mixed_phase(RANDOM_PER_PHASE);

        write_threshold(16'hFFFF);
        steady = 1'b1;
        mixed_phase(RANDOM_PER_PHASE);
        steady = 1'b0;

        write_threshold(IOU_THRESHOLD_RESET);
        mixed_phase(RANDOM_PER_PHASE);

        write_threshold(16'($urandom));
        mixed_phase(RANDOM_PER_PHASE);

        // drain
        s_valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (verdicts_due.size() != 0)
            log_fault($sformatf("%0d verdicts never matched", verdicts_due.size()));

        $display("run: %0d boxes in, %0d words out (%0d kept, %0d suppressed, %0d store full)",
                 boxes_sent, results_seen, seen_kept, seen_supp, seen_full);
        $display("run: %0d threshold writes, %0d output hold-offs, %0d mismatches",
                 thr_writes, holds_done, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
